// ===== rtl/core/sci_pkg.sv =====
// ----------------------------------------------------------------------------
// sci_pkg
// Shared widths and the segment payload type for the segment/cylinder core.
// ----------------------------------------------------------------------------
package sci_pkg;

	// coordinate, direction and radius widths
	localparam int CRD_W  = 32;
	localparam int VEC_W  = 33;
	localparam int RAD_W  = 31;

	// quadratic coefficients a (unsigned), b and c (signed)
	localparam int A_W    = 66;
	localparam int B_W    = 66;
	localparam int C_W    = 65;

	// discriminant, split half width for partial products
	localparam int D_W    = 132;
	localparam int HALF_W = 33;

	// square root: result bits and working width
	localparam int RT_W   = 66;
	localparam int SQ_W   = 133;

	// numerator -b - s
	localparam int N_W    = 68;

	// segment start and direction carried down the pipeline
	typedef struct packed {
		logic signed [CRD_W-1:0] ax;
		logic signed [CRD_W-1:0] ay;
		logic signed [CRD_W-1:0] az;
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic signed [VEC_W-1:0] vz;
	} seg_t;

endpackage

// ===== rtl/core/sci_coef.sv =====
// ----------------------------------------------------------------------------
// sci_coef
// Six stages: direction vector, coefficients a, b, c and the discriminant
// D = b*b - a*c built from partial products of 33-bit halves.
// ----------------------------------------------------------------------------
module sci_coef (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [sci_pkg::CRD_W-1:0]    start_x,
	input  logic signed [sci_pkg::CRD_W-1:0]    start_y,
	input  logic signed [sci_pkg::CRD_W-1:0]    start_z,
	input  logic signed [sci_pkg::CRD_W-1:0]    end_x,
	input  logic signed [sci_pkg::CRD_W-1:0]    end_y,
	input  logic signed [sci_pkg::CRD_W-1:0]    end_z,
	input  logic        [sci_pkg::RAD_W-1:0]    radius,
	output logic                                out_valid,
	output sci_pkg::seg_t                       seg,
	output logic        [sci_pkg::A_W-1:0]      coef_a,
	output logic signed [sci_pkg::B_W-1:0]      coef_b,
	output logic        [sci_pkg::D_W-1:0]      disc,
	output logic                                ok
);

	localparam int HW = sci_pkg::HALF_W;
	localparam int DW = sci_pkg::D_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	sci_pkg::seg_t seg_s1, seg_s2, seg_s3, seg_s4, seg_s5, seg_s6;
	logic [sci_pkg::RAD_W-1:0] r_s1;

	logic signed [2*sci_pkg::VEC_W-1:0]             vxx_s2, vyy_s2;
	logic signed [sci_pkg::VEC_W+sci_pkg::CRD_W-1:0] vxax_s2, vyay_s2;
	logic signed [2*sci_pkg::CRD_W-1:0]             axx_s2, ayy_s2;
	logic        [2*sci_pkg::RAD_W-1:0]             rr_s2;

	logic        [sci_pkg::A_W-1:0] a_s3, a_s4, a_s5, a_s6;
	logic signed [sci_pkg::B_W-1:0] b_s3, b_s4, b_s5, b_s6;
	logic signed [sci_pkg::C_W-1:0] c_s3;

	logic signed [2*HW-1:0] pbhh_s4;
	logic signed [2*HW:0]   pbhl_s4;
	logic        [2*HW-1:0] pbll_s4;
	logic signed [2*HW-1:0] pahch_s4;
	logic        [2*HW-1:0] pahcl_s4;
	logic signed [2*HW-1:0] palch_s4;
	logic        [2*HW-1:0] palcl_s4;

	logic signed [DW-1:0] b2_s5, ac_s5, dd;
	logic        [DW-1:0] d_s6;
	logic                 ok_s6;

	// signed views of stage 1 payload
	logic signed [sci_pkg::VEC_W-1:0] vx1, vy1;
	logic signed [sci_pkg::CRD_W-1:0] ax1, ay1;

	// halves of b, a and c
	logic signed [HW-1:0]   bh;
	logic signed [HW:0]     bl_x;
	logic        [HW-1:0]   bl, ah, al, cl;
	logic signed [HW:0]     ah_x, al_x;
	logic signed [sci_pkg::C_W-HW-1:0] ch;

	assign vx1  = seg_s1.vx;
	assign vy1  = seg_s1.vy;
	assign ax1  = seg_s1.ax;
	assign ay1  = seg_s1.ay;

	assign bh   = b_s3[sci_pkg::B_W-1:HW];
	assign bl   = b_s3[HW-1:0];
	assign bl_x = {1'b0, bl};
	assign ah   = a_s3[sci_pkg::A_W-1:HW];
	assign al   = a_s3[HW-1:0];
	assign ah_x = {1'b0, ah};
	assign al_x = {1'b0, al};
	assign ch   = c_s3[sci_pkg::C_W-1:HW];
	assign cl   = c_s3[HW-1:0];

	assign dd   = b2_s5 - ac_s5;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: start point and direction
			seg_s1.ax <= start_x;
			seg_s1.ay <= start_y;
			seg_s1.az <= start_z;
			seg_s1.vx <= sci_pkg::VEC_W'(end_x) - sci_pkg::VEC_W'(start_x);
			seg_s1.vy <= sci_pkg::VEC_W'(end_y) - sci_pkg::VEC_W'(start_y);
			seg_s1.vz <= sci_pkg::VEC_W'(end_z) - sci_pkg::VEC_W'(start_z);
			r_s1      <= radius;

			// stage 2: squares and cross products
			vxx_s2  <= vx1 * vx1;
			vyy_s2  <= vy1 * vy1;
			vxax_s2 <= vx1 * ax1;
			vyay_s2 <= vy1 * ay1;
			axx_s2  <= ax1 * ax1;
			ayy_s2  <= ay1 * ay1;
			rr_s2   <= r_s1 * r_s1;
			seg_s2  <= seg_s1;

			// stage 3: coefficients
			a_s3   <= sci_pkg::A_W'($unsigned(vxx_s2)) + sci_pkg::A_W'($unsigned(vyy_s2));
			b_s3   <= sci_pkg::B_W'(vxax_s2) + sci_pkg::B_W'(vyay_s2);
			c_s3   <= sci_pkg::C_W'(axx_s2) + sci_pkg::C_W'(ayy_s2)
				- $signed(sci_pkg::C_W'(rr_s2));
			seg_s3 <= seg_s2;

			// stage 4: partial products of b*b and a*c
			pbhh_s4  <= bh * bh;
			pbhl_s4  <= bh * bl_x;
			pbll_s4  <= bl * bl;
			pahch_s4 <= ah_x * ch;
			pahcl_s4 <= ah * cl;
			palch_s4 <= al_x * ch;
			palcl_s4 <= al * cl;
			a_s4     <= a_s3;
			b_s4     <= b_s3;
			seg_s4   <= seg_s3;

			// stage 5: reassemble b*b and a*c
			b2_s5  <= (DW'(pbhh_s4) << (2*HW)) + (DW'(pbhl_s4) << (HW+1))
				+ DW'(pbll_s4);
			ac_s5  <= (DW'(pahch_s4) << (2*HW)) + (DW'(pahcl_s4) << HW)
				+ (DW'(palch_s4) << HW) + DW'(palcl_s4);
			a_s5   <= a_s4;
			b_s5   <= b_s4;
			seg_s5 <= seg_s4;

			// stage 6: discriminant and early reject
			d_s6   <= dd;
			ok_s6  <= (a_s5 != '0) && !dd[DW-1];
			a_s6   <= a_s5;
			b_s6   <= b_s5;
			seg_s6 <= seg_s5;
		end
	end

	assign out_valid = v_s6;
	assign seg       = seg_s6;
	assign coef_a    = a_s6;
	assign coef_b    = b_s6;
	assign disc      = d_s6;
	assign ok        = ok_s6;

endmodule

// ===== rtl/core/sci_sqrt.sv =====
// ----------------------------------------------------------------------------
// sci_sqrt
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sci_sqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  sci_pkg::seg_t                   in_seg,
	input  logic        [sci_pkg::A_W-1:0]  in_a,
	input  logic signed [sci_pkg::B_W-1:0]  in_b,
	input  logic        [sci_pkg::D_W-1:0]  in_d,
	input  logic                            in_ok,
	output logic                            out_valid,
	output sci_pkg::seg_t                   out_seg,
	output logic        [sci_pkg::A_W-1:0]  out_a,
	output logic signed [sci_pkg::B_W-1:0]  out_b,
	output logic        [sci_pkg::RT_W-1:0] out_root,
	output logic                            out_ok
);

	localparam int NS = sci_pkg::RT_W;
	localparam int SW = sci_pkg::SQ_W;

	// index 0 is the stage input, index k the register after stage k
	logic                           vld_s [NS+1];
	logic        [SW-1:0]           op_s  [NS+1];
	logic        [SW-1:0]           res_s [NS+1];
	sci_pkg::seg_t                  seg_s [NS+1];
	logic        [sci_pkg::A_W-1:0] a_s   [NS+1];
	logic signed [sci_pkg::B_W-1:0] b_s   [NS+1];
	logic                           ok_s  [NS+1];

	assign vld_s[0] = in_valid;
	assign op_s[0]  = SW'(in_d);
	assign res_s[0] = '0;
	assign seg_s[0] = in_seg;
	assign a_s[0]   = in_a;
	assign b_s[0]   = in_b;
	assign ok_s[0]  = in_ok;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam logic [SW-1:0] ONE = SW'(1) << (2*(NS-1-k));

		logic [SW-1:0] trial;
		logic          take;

		// try setting this root bit
		assign trial = res_s[k] + ONE;
		assign take  = op_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				op_s[k+1]  <= take ? (op_s[k] - trial) : op_s[k];
				res_s[k+1] <= take ? ((res_s[k] >> 1) + ONE) : (res_s[k] >> 1);
				seg_s[k+1] <= seg_s[k];
				a_s[k+1]   <= a_s[k];
				b_s[k+1]   <= b_s[k];
				ok_s[k+1]  <= ok_s[k];
			end
		end
	end

	assign out_valid = vld_s[NS];
	assign out_seg   = seg_s[NS];
	assign out_a     = a_s[NS];
	assign out_b     = b_s[NS];
	assign out_root  = res_s[NS][sci_pkg::RT_W-1:0];
	assign out_ok    = ok_s[NS];

endmodule

// ===== rtl/core/sci_div.sv =====
// ----------------------------------------------------------------------------
// sci_div
// Nearer root n = -b - s, range check 0 <= n <= a, then a pipelined
// restoring divide t = floor((2n*2^F + a) / 2a), one quotient bit per stage.
// ----------------------------------------------------------------------------
module sci_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  sci_pkg::seg_t                   in_seg,
	input  logic        [sci_pkg::A_W-1:0]  in_a,
	input  logic signed [sci_pkg::B_W-1:0]  in_b,
	input  logic        [sci_pkg::RT_W-1:0] in_root,
	input  logic                            in_ok,
	output logic                            out_valid,
	output sci_pkg::seg_t                   out_seg,
	output logic        [FRAC_BITS+1:0]     out_q,
	output logic                            out_hit
);

	localparam int Q_W   = FRAC_BITS + 2;
	localparam int NUM_W = sci_pkg::A_W + FRAC_BITS + 2;
	localparam int DEN_W = sci_pkg::A_W + 1;
	localparam int NW    = sci_pkg::N_W;

	logic signed [NW-1:0] n;

	logic                vld_s [Q_W+1];
	logic [NUM_W-1:0]    rem_s [Q_W+1];
	logic [DEN_W-1:0]    den_s [Q_W+1];
	logic [Q_W-1:0]      q_s   [Q_W+1];
	sci_pkg::seg_t       seg_s [Q_W+1];
	logic                hit_s [Q_W+1];

	// nearer root numerator
	assign n = -NW'(in_b) - $signed(NW'(in_root));

	// stage 0: range check and divider setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s[0] <= in_ok && !n[NW-1] && (n[NW-2:0] <= (NW-1)'(in_a));
			rem_s[0] <= (NUM_W'(n[sci_pkg::A_W-1:0]) << (FRAC_BITS+1)) + NUM_W'(in_a);
			den_s[0] <= DEN_W'(in_a) << 1;
			q_s[0]   <= '0;
			seg_s[0] <= in_seg;
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		localparam int BIT = Q_W - 1 - k;

		logic [NUM_W-1:0] dsh;
		logic             take;

		// compare against shifted divisor
		assign dsh  = NUM_W'(den_s[k]) << BIT;
		assign take = rem_s[k] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? (rem_s[k] - dsh) : rem_s[k];
				q_s[k+1]   <= take ? (q_s[k] | (Q_W'(1) << BIT)) : q_s[k];
				den_s[k+1] <= den_s[k];
				seg_s[k+1] <= seg_s[k];
				hit_s[k+1] <= hit_s[k];
			end
		end
	end

	assign out_valid = vld_s[Q_W];
	assign out_seg   = seg_s[Q_W];
	assign out_q     = q_s[Q_W];
	assign out_hit   = hit_s[Q_W];

endmodule

// ===== rtl/core/sci_point.sv =====
// ----------------------------------------------------------------------------
// sci_point
// Hit point A + v*t: product, round to nearest (ties away from zero),
// then add and saturate. Fields are zeroed when there is no hit.
// ----------------------------------------------------------------------------
module sci_point #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  sci_pkg::seg_t                     in_seg,
	input  logic        [FRAC_BITS+1:0]       in_q,
	input  logic                              in_hit,
	output logic                              out_valid,
	output logic                              hit,
	output logic        [FRAC_BITS:0]         param_t,
	output logic signed [sci_pkg::CRD_W-1:0]  point_x,
	output logic signed [sci_pkg::CRD_W-1:0]  point_y,
	output logic signed [sci_pkg::CRD_W-1:0]  point_z
);

	localparam int Q_W   = FRAC_BITS + 2;
	localparam int P_W   = sci_pkg::VEC_W + Q_W + 1;
	localparam int SC_W  = P_W - FRAC_BITS + 1;
	localparam int SUM_W = SC_W + 1;
	localparam int CW    = sci_pkg::CRD_W;
	localparam logic [P_W-1:0] HALF_LSB = P_W'(1) << (FRAC_BITS - 1);

	// magnitude round with ties away from zero, sign restored
	function automatic logic signed [SC_W-1:0] round_scale(input logic signed [P_W-1:0] p);
		logic [P_W-1:0] mag;
		logic [P_W-1:0] rnd;
		mag = p[P_W-1] ? P_W'(-p) : P_W'(p);
		rnd = (mag + HALF_LSB) >> FRAC_BITS;
		return p[P_W-1] ? -$signed(SC_W'(rnd)) : $signed(SC_W'(rnd));
	endfunction

	// clamp to the 32-bit signed range
	function automatic logic [CW-1:0] sat(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-CW:0] top;
		top = s[SUM_W-1:CW-1];
		if (top == '0 || top == '1) begin
			return s[CW-1:0];
		end else if (s[SUM_W-1]) begin
			return {1'b1, {(CW-1){1'b0}}};
		end else begin
			return {1'b0, {(CW-1){1'b1}}};
		end
	endfunction

	logic v_s1, v_s2, v_s3;

	logic signed [Q_W:0]          qx;
	logic signed [sci_pkg::VEC_W-1:0] vx0, vy0, vz0;

	logic signed [P_W-1:0]  px_s1, py_s1, pz_s1;
	logic signed [SC_W-1:0] sx_s2, sy_s2, sz_s2;
	logic signed [CW-1:0]   ax_s1, ay_s1, az_s1, ax_s2, ay_s2, az_s2;
	logic [Q_W-1:0]         q_s1, q_s2;
	logic                   hit_s1, hit_s2, hit_s3;
	logic [FRAC_BITS:0]     t_s3;
	logic [CW-1:0]          x_s3, y_s3, z_s3;

	assign qx  = {1'b0, in_q};
	assign vx0 = in_seg.vx;
	assign vy0 = in_seg.vy;
	assign vz0 = in_seg.vz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: v * t
			px_s1  <= vx0 * qx;
			py_s1  <= vy0 * qx;
			pz_s1  <= vz0 * qx;
			ax_s1  <= in_seg.ax;
			ay_s1  <= in_seg.ay;
			az_s1  <= in_seg.az;
			q_s1   <= in_q;
			hit_s1 <= in_hit;

			// stage 2: drop fraction bits with rounding
			sx_s2  <= round_scale(px_s1);
			sy_s2  <= round_scale(py_s1);
			sz_s2  <= round_scale(pz_s1);
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			az_s2  <= az_s1;
			q_s2   <= q_s1;
			hit_s2 <= hit_s1;

			// stage 3: add start point, saturate, zero on miss
			x_s3   <= hit_s2 ? sat(SUM_W'(ax_s2) + SUM_W'(sx_s2)) : '0;
			y_s3   <= hit_s2 ? sat(SUM_W'(ay_s2) + SUM_W'(sy_s2)) : '0;
			z_s3   <= hit_s2 ? sat(SUM_W'(az_s2) + SUM_W'(sz_s2)) : '0;
			t_s3   <= hit_s2 ? q_s2[FRAC_BITS:0] : '0;
			hit_s3 <= hit_s2;
		end
	end

	assign out_valid = v_s3;
	assign hit       = hit_s3;
	assign param_t   = t_s3;
	assign point_x   = x_s3;
	assign point_y   = y_s3;
	assign point_z   = z_s3;

endmodule

// ===== rtl/core/segment_cylinder_intersect_core.sv =====
// ----------------------------------------------------------------------------
// segment_cylinder_intersect_core
// Segment against an infinite cylinder about the z axis, one item per cycle
// while in_stall is low. It runs through the coefficient stages, the 66-stage
// square root, the FRAC_BITS+2 stage divider and the point stages.
// A two-entry output queue absorbs stalls until full; then the pipeline holds.
// Reset clears all valid bits, the queue count and the radius register (0).
// ----------------------------------------------------------------------------
module segment_cylinder_intersect_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic        [sci_pkg::RAD_W-1:0]  cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [sci_pkg::CRD_W-1:0]  start_x,
	input  logic signed [sci_pkg::CRD_W-1:0]  start_y,
	input  logic signed [sci_pkg::CRD_W-1:0]  start_z,
	input  logic signed [sci_pkg::CRD_W-1:0]  end_x,
	input  logic signed [sci_pkg::CRD_W-1:0]  end_y,
	input  logic signed [sci_pkg::CRD_W-1:0]  end_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic        [FRAC_BITS:0]         param_t,
	output logic signed [sci_pkg::CRD_W-1:0]  point_x,
	output logic signed [sci_pkg::CRD_W-1:0]  point_y,
	output logic signed [sci_pkg::CRD_W-1:0]  point_z
);

	localparam int CW = sci_pkg::CRD_W;
	localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	logic [sci_pkg::RAD_W-1:0] radius_q;
	logic                      en;

	// coefficient stage outputs
	logic                           cf_valid, cf_ok;
	sci_pkg::seg_t                  cf_seg;
	logic        [sci_pkg::A_W-1:0] cf_a;
	logic signed [sci_pkg::B_W-1:0] cf_b;
	logic        [sci_pkg::D_W-1:0] cf_d;

	// square root outputs
	logic                            sq_valid, sq_ok;
	sci_pkg::seg_t                   sq_seg;
	logic        [sci_pkg::A_W-1:0]  sq_a;
	logic signed [sci_pkg::B_W-1:0]  sq_b;
	logic        [sci_pkg::RT_W-1:0] sq_root;

	// divider outputs
	logic                   dv_valid, dv_hit;
	sci_pkg::seg_t          dv_seg;
	logic [FRAC_BITS+1:0]   dv_q;

	// point stage outputs
	logic                   pt_valid, pt_hit;
	logic [FRAC_BITS:0]     pt_t;
	logic signed [CW-1:0]   pt_x, pt_y, pt_z;

	// output queue
	logic                 hit_q [2];
	logic [FRAC_BITS:0]   t_q   [2];
	logic [CW-1:0]        x_q   [2];
	logic [CW-1:0]        y_q   [2];
	logic [CW-1:0]        z_q   [2];
	logic                 wr_ptr_q, rd_ptr_q;
	logic [1:0]           cnt_q;
	logic                 push, pop;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (cfg_wr_en) begin
			radius_q <= cfg_wr_data;
		end
	end

	// pipeline advances while the queue has a free entry
	assign en       = (cnt_q != 2'd2);
	assign in_stall = !en;

	sci_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.start_x   (start_x),
		.start_y   (start_y),
		.start_z   (start_z),
		.end_x     (end_x),
		.end_y     (end_y),
		.end_z     (end_z),
		.radius    (radius_q),
		.out_valid (cf_valid),
		.seg       (cf_seg),
		.coef_a    (cf_a),
		.coef_b    (cf_b),
		.disc      (cf_d),
		.ok        (cf_ok)
	);

	sci_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cf_valid),
		.in_seg    (cf_seg),
		.in_a      (cf_a),
		.in_b      (cf_b),
		.in_d      (cf_d),
		.in_ok     (cf_ok),
		.out_valid (sq_valid),
		.out_seg   (sq_seg),
		.out_a     (sq_a),
		.out_b     (sq_b),
		.out_root  (sq_root),
		.out_ok    (sq_ok)
	);

	sci_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_seg    (sq_seg),
		.in_a      (sq_a),
		.in_b      (sq_b),
		.in_root   (sq_root),
		.in_ok     (sq_ok),
		.out_valid (dv_valid),
		.out_seg   (dv_seg),
		.out_q     (dv_q),
		.out_hit   (dv_hit)
	);

	sci_point #(
		.FRAC_BITS (FRAC_BITS)
	) u_point (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.in_seg    (dv_seg),
		.in_q      (dv_q),
		.in_hit    (dv_hit),
		.out_valid (pt_valid),
		.hit       (pt_hit),
		.param_t   (pt_t),
		.point_x   (pt_x),
		.point_y   (pt_y),
		.point_z   (pt_z)
	);

	// output queue control
	assign push = en && pt_valid;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// output queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			hit_q[wr_ptr_q] <= pt_hit;
			t_q[wr_ptr_q]   <= pt_t;
			x_q[wr_ptr_q]   <= pt_x;
			y_q[wr_ptr_q]   <= pt_y;
			z_q[wr_ptr_q]   <= pt_z;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign hit       = hit_q[rd_ptr_q];
	assign param_t   = t_q[rd_ptr_q];
	assign point_x   = x_q[rd_ptr_q];
	assign point_y   = y_q[rd_ptr_q];
	assign point_z   = z_q[rd_ptr_q];

	// queue never overfills
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue count out of range");

	// a miss carries all-zero result fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (param_t == '0 && point_x == '0 &&
		point_y == '0 && point_z == '0))
		else $error("miss with nonzero result fields");

	// a hit never reports t above 1.0
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (param_t <= T_ONE))
		else $error("hit with t above 1.0");

endmodule

// ===== test/segment_cylinder_intersect_core_tb.sv =====
// ----------------------------------------------------------------------------
// segment_cylinder_intersect_core_tb
// Drives segments into the cylinder core under several radius settings and
// checks every result against its typed row or an exact wide-integer model
// of the quadratic, integer square root, rounded t and saturated hit point.
// ----------------------------------------------------------------------------
module segment_cylinder_intersect_core_tb;

	localparam int CRD_W     = sci_pkg::CRD_W;
	localparam int RAD_W     = sci_pkg::RAD_W;

	localparam int FRAC      = 16;
	localparam int LIMIT     = 600000;
	localparam int DRAIN     = 200;
	localparam int N_PHASES  = 6;
	localparam int PHASE_LEN = 250;
	localparam int ONE       = 1 << FRAC;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic signed [CRD_W-1:0] sx, sy, sz, ex, ey, ez;
	} segment_t;

	typedef struct {
		logic              hit;
		logic [FRAC:0]     t;
		logic signed [31:0] px, py, pz;
	} crossing_t;

	typedef struct {
		segment_t  seg;
		logic      typed;
		crossing_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [RAD_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CRD_W-1:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [CRD_W-1:0] end_x = '0, end_y = '0, end_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic [FRAC:0] param_t;
	logic signed [CRD_W-1:0] point_x, point_y, point_z;

	crossing_t pending_hits[$];
	logic [RAD_W-1:0] cur_radius = '0;
	int in_idle_pct = 0, out_idle_pct = 0;
	int hold_left = 0;
	int n_errors = 0, n_results = 0, n_hits = 0, cycles = 0;

	segment_cylinder_intersect_core #(.FRAC_BITS(FRAC)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.end_x(end_x), .end_y(end_y), .end_z(end_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .param_t(param_t),
		.point_x(point_x), .point_y(point_y), .point_z(point_z)
	);

	always #1 clk = ~clk;

	// round v*t/2^FRAC to nearest, ties away from zero
	function automatic wide_t scale_round(wide_t v, wide_t t);
		wide_t prod, mag;
		prod = v * t;
		mag = (prod < 0) ? -prod : prod;
		mag = (mag + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
		return (prod < 0) ? -mag : mag;
	endfunction

	function automatic logic signed [31:0] clamp32(wide_t v);
		if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -64'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	// exact nearer-root intersection of a segment with the cylinder
	function automatic crossing_t cylinder_crossing(segment_t s, logic [RAD_W-1:0] rad);
		wide_t ax, ay, az, vx, vy, vz, r, qa, qb, qc, disc, root, cand, n, q;
		crossing_t res;
		ax = s.sx; ay = s.sy; az = s.sz;
		vx = wide_t'(s.ex) - ax;
		vy = wide_t'(s.ey) - ay;
		vz = wide_t'(s.ez) - az;
		r = $signed({1'b0, rad});
		qa = vx * vx + vy * vy;
		qb = vx * ax + vy * ay;
		qc = ax * ax + ay * ay - r * r;
		disc = qb * qb - qa * qc;
		res = '{hit: 1'b0, t: '0, px: '0, py: '0, pz: '0};
		if (qa != 0 && disc >= 0) begin
			root = 0;
			for (int b = 70; b >= 0; b--) begin
				cand = root | (wide_t'(1) <<< b);
				if (cand * cand <= disc) root = cand;
			end
			n = -qb - root;
			if (n >= 0 && n <= qa) begin
				q = ((n <<< (FRAC + 1)) + qa) / (qa + qa);
				res.hit = 1'b1;
				res.t = q[FRAC:0];
				res.px = clamp32(ax + scale_round(vx, q));
				res.py = clamp32(ay + scale_round(vy, q));
				res.pz = clamp32(az + scale_round(vz, q));
			end
		end
		return res;
	endfunction

	// signed value in [-span, span]
	function automatic logic signed [31:0] coord_near(int unsigned span);
		return $signed($urandom_range(2 * span)) - $signed(span);
	endfunction

	// mostly segments scaled to the radius, plus noise and degenerate cases
	function automatic segment_t random_segment(logic [RAD_W-1:0] rad);
		segment_t s;
		int unsigned span, sel;
		span = (rad > 31'h1FFFFFFF) ? 32'h3FFFFFFF : 2 * rad + 1000;
		sel = $urandom_range(99);
		s.sx = coord_near(span); s.sy = coord_near(span); s.sz = $urandom;
		s.ex = coord_near(span); s.ey = coord_near(span); s.ez = $urandom;
		if (sel < 20) begin
			s.sx = $urandom; s.sy = $urandom; s.ex = $urandom; s.ey = $urandom;
		end else if (sel < 28) begin
			s.ex = s.sx; s.ey = s.sy;
		end else if (sel < 38) begin
			// horizontal chord near the tangent line y = +-radius
			s.sy = ($urandom_range(1) ? rad : -rad) + $signed($urandom_range(4)) - 2;
			s.ey = s.sy;
		end else if (sel < 43) begin
			s.sx = 0; s.sy = 0;
		end
		return s;
	endfunction

	// present one item and wait for it to be taken
	task automatic send_segment(segment_t s, logic typed, crossing_t res);
		int gap;
		gap = 0;
		while ($urandom_range(99) < in_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_x <= s.sx; start_y <= s.sy; start_z <= s.sz;
		end_x <= s.ex; end_y <= s.ey; end_z <= s.ez;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_hits.push_back(typed ? res : cylinder_crossing(s, cur_radius));
	endtask

	task automatic drain_results();
		while (pending_hits.size() != 0) @(posedge clk);
	endtask

	task automatic write_radius(logic [RAD_W-1:0] rad);
		in_valid <= 1'b0;
		drain_results();
		repeat (DRAIN) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= rad;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_radius = rad;
	endtask

	// result side: random or held stall, compare against oldest expectation
	always @(posedge clk) begin
		crossing_t e;
		if (out_valid && !out_stall) begin
			if (pending_hits.size() == 0) begin
				$error("result with no item outstanding");
				n_errors++;
			end else begin
				e = pending_hits.pop_front();
				n_results++;
				if (e.hit) n_hits++;
				if (hit !== e.hit) begin
					$error("hit: expected %0d actual %0d", e.hit, hit); n_errors++;
				end
				if (param_t !== e.t) begin
					$error("param_t: expected %0d actual %0d", e.t, param_t); n_errors++;
				end
				if (point_x !== e.px) begin
					$error("point_x: expected %0d actual %0d", e.px, point_x); n_errors++;
				end
				if (point_y !== e.py) begin
					$error("point_y: expected %0d actual %0d", e.py, point_y); n_errors++;
				end
				if (point_z !== e.pz) begin
					$error("point_z: expected %0d actual %0d", e.pz, point_z); n_errors++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < out_idle_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		crossing_t none;
		logic [RAD_W-1:0] radii[N_PHASES];
		none = '{hit: 1'b0, t: '0, px: '0, py: '0, pz: '0};

		// directed rows at the reset radius of zero
		rows.push_back('{'{0, 0, 0, 0, 0, ONE}, 1'b1, none});              // axis parallel
		rows.push_back('{'{-ONE, 0, 0, ONE, 0, 0}, 1'b1,
			'{1'b1, 17'd32768, 0, 0, 0}});                                 // through axis
		rows.push_back('{'{7, 9, 3, 7, 9, 3}, 1'b1, none});               // zero length
		rows.push_back('{'{0, 0, 5 * ONE, ONE, 0, 7 * ONE}, 1'b1,
			'{1'b1, 17'd0, 0, 0, 5 * ONE}});                               // starts on axis
		rows.push_back('{'{ONE, 0, 0, 0, 0, 0}, 1'b1,
			'{1'b1, 17'd65536, 0, 0, 0}});                                 // ends on axis
		rows.push_back('{'{32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 1'b0, none});
		rows.push_back('{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh80000000, 32'sh80000000}, 1'b0, none});
		rows.push_back('{'{ONE, ONE, 0, 2 * ONE, 2 * ONE, 0}, 1'b0, none});
		rows.push_back('{'{32'sh7FFFFFFF, 0, 0, 32'sh80000000, 1, 32'sh7FFFFFFF},
			1'b0, none});

		radii = '{31'd0, 31'h7FFFFFFF, 31'd655360, 31'd1, 31'($urandom), 31'd0};

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_segment(rows[i].seg, rows[i].typed, rows[i].res);

		// radius 10.0: inside start, tangents, a plain crossing and a clear miss
		write_radius(31'd655360);
		rows.delete();
		rows.push_back('{'{0, 0, 0, 20 * ONE, 0, 0}, 1'b1, none});         // start inside
		rows.push_back('{'{-20 * ONE, 10 * ONE, 0, 20 * ONE, 10 * ONE, 0}, 1'b0, none});
		rows.push_back('{'{5 * ONE, 10 * ONE, 0, 20 * ONE, 10 * ONE, 0}, 1'b1, none});
		rows.push_back('{'{-20 * ONE, 0, 3 * ONE, 20 * ONE, 0, 3 * ONE}, 1'b1,
			'{1'b1, 17'd16384, -10 * ONE, 0, 3 * ONE}});
		rows.push_back('{'{-20 * ONE, 30 * ONE, 0, 20 * ONE, 30 * ONE, 0}, 1'b1, none});
		foreach (rows[i]) send_segment(rows[i].seg, rows[i].typed, rows[i].res);

		// random phases: the radius changes between them, the idling every two phases
		for (int p = 0; p < N_PHASES; p++) begin
			write_radius(radii[p]);
			case (p / 2)
				0: begin in_idle_pct = 26; out_idle_pct = 55; end
				1: begin in_idle_pct = 55; out_idle_pct = 26; end
				default: begin in_idle_pct = 0; out_idle_pct = 0; end
			endcase
			if (p == 4) hold_left = 500;  // long hold with a full-rate sender
			for (int k = 0; k < PHASE_LEN; k++) begin
				if (p == 3 && k == PHASE_LEN / 2) begin
					in_valid <= 1'b0;
					drain_results();
				end
				send_segment(random_segment(cur_radius), 1'b0, none);
			end
		end
		in_valid <= 1'b0;

		drain_results();
		repeat (DRAIN) @(posedge clk);
		$display("Covered %0d results (%0d hits) over %0d radius settings,",
			n_results, n_hits, N_PHASES + 2);
		$display("with input/output idling, a long output hold and a full drain.");
		if (n_errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
